// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a named clock and active-low reset.
`define HMT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define HMT_ASSERT(lbl, prop, msg) \
  `HMT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/hmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hmt_pkg: shared types and constants
// Transaction payloads, register indexes and pixel class codes of the
// binary hit-or-miss transform.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam logic [14:0] HIT_VALUE = 15'd32640;
  localparam int unsigned CFG_DW    = 49;
  localparam int unsigned CFG_IW    = 3;

  // Per-pixel source class
  localparam logic [1:0] CLS_ZERO  = 2'd0;
  localparam logic [1:0] CLS_HIT   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  typedef enum logic [CFG_IW-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_KERNEL_WIDTH  = 3'd2,
    CFG_KERNEL_HEIGHT = 3'd3,
    CFG_CARE_MASK     = 3'd4,
    CFG_VALUE_MASK    = 3'd5,
    CFG_PASS_COUNT    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [14:0] luma;
  } in_item_t;

  typedef struct packed {
    logic [14:0] pixel_value;
    logic        frame_end;
  } out_item_t;

endpackage

// ===== hdl/hmt_stream_if.sv =====
// ----------------------------------------------------------------------------
// hmt_stream_if: valid/ready channel
// Carries one payload per transaction, accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface hmt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/hmt_ram.sv =====
// ----------------------------------------------------------------------------
// hmt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hmt_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/binary_hit_or_miss_transform.sv =====
// Loads: one load per cycle while idle, unless a configuration write or a stalled output holds
// the input. A read result passes through the result RAM read register into the output register.
// The frame-completing write starts pass_count passes; in each pass the tap sequencer reads every
// tap of each pixel, compares the in-frame care taps and writes the pixel result, then copies
// each result back with a read and a write. A read holds off the input until its result is
// registered for output. Reset: configuration returns to 320x240, 3x3 kernel, one pass.
// ----------------------------------------------------------------------------
// binary_hit_or_miss_transform: top level
// Loads a luma frame, runs the hit-or-miss passes with one shared tap
// sequencer over a class RAM and a result RAM, and drains the results.
// No frame is held after reset; the frame stores are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_hit_or_miss_transform #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_KERNEL = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hmt_stream_if.sink                 in_if,
  hmt_stream_if.source               out_if,
  input  logic                       cfg_we_i,
  input  logic [hmt_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [hmt_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned XW = $clog2(MAX_WIDTH + MAX_KERNEL) + 1;
  localparam int unsigned YW = $clog2(MAX_HEIGHT + MAX_KERNEL) + 1;
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_TAP_RD  = 6'b000010,
    S_TAP_CMP = 6'b000100,
    S_PIX_WR  = 6'b001000,
    S_CP_RD   = 6'b010000,
    S_CP_WR   = 6'b100000
  } state_e;

  // Configuration registers
  logic [9:0]  fw_q, fh_q;
  logic [2:0]  kw_q, kh_q;
  logic [48:0] care_q, val_q;
  logic [7:0]  npass_q;
  logic        cfg_busy_q;

  // Sequencer state
  state_e               state_q;
  logic [AW-1:0]        pix_q, tap_addr_q, wp_q, rp_q;
  logic signed [XW-1:0] px_q, tx_q;
  logic signed [YW-1:0] py_q, ty_q;
  logic [2:0]           r_q, c_q;
  logic [5:0]           bit_q;
  logic                 hit_q;
  logic [7:0]           pass_q;
  logic                 frame_rdy_q;
  logic                 pend_q, pend_end_q;
  logic                 out_valid_q;
  hmt_pkg::out_item_t   out_q;

  // Derived geometry
  logic [NW-1:0]        n_q;
  logic [AW-1:0]        koff_q, rstep_q;
  logic [XW-1:0]        w_eff;
  logic [YW-1:0]        h_eff;
  logic [2:0]           kwc, khc, kw_eff, kh_eff;
  logic [1:0]           kx, ky;

  // RAM ports
  logic          src_we, res_we;
  logic [AW-1:0] src_waddr, res_waddr, res_raddr;
  logic [1:0]    src_wdata, src_rdata;
  logic          res_wdata, res_rdata;

  // Control helpers
  logic                 in_acc, tap_ok, last_tap, last_pix, cls_match;
  logic signed [XW-1:0] nx;
  logic signed [YW-1:0] ny;
  logic [1:0]           in_cls;

  // Clamp frame and kernel sizes; round even kernel sizes down to odd
  always_comb begin
    if (fw_q == 10'd0) w_eff = XW'(1);
    else if (int'(fw_q) > int'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(fw_q);
    if (fh_q == 10'd0) h_eff = YW'(1);
    else if (int'(fh_q) > int'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(fh_q);
    if (kw_q == 3'd0) kwc = 3'd1;
    else if (int'(kw_q) > int'(MAX_KERNEL)) kwc = 3'(MAX_KERNEL);
    else kwc = kw_q;
    if (kh_q == 3'd0) khc = 3'd1;
    else if (int'(kh_q) > int'(MAX_KERNEL)) khc = 3'(MAX_KERNEL);
    else khc = kh_q;
    kw_eff = kwc[0] ? kwc : kwc - 3'd1;
    kh_eff = khc[0] ? khc : khc - 3'd1;
    kx     = kw_eff[2:1];
    ky     = kh_eff[2:1];
  end

  // Register pixel count and tap address offsets
  always_ff @(posedge clk_i) begin
    n_q     <= NW'(w_eff * h_eff);
    koff_q  <= AW'(int'(ky) * int'(w_eff) + int'(kx));
    rstep_q <= AW'(int'(w_eff) - int'(kw_eff) + 1);
  end

  // Tap and pixel decode
  always_comb begin
    in_acc   = in_if.valid && in_if.ready;
    tap_ok   = (tx_q >= 0) && (tx_q < $signed(w_eff)) &&
               (ty_q >= 0) && (ty_q < $signed(h_eff)) && care_q[bit_q];
    last_tap = (r_q == kh_eff - 3'd1) && (c_q == kw_eff - 3'd1);
    last_pix = ({1'b0, pix_q} == n_q - NW'(1));
    cls_match = (src_rdata == {1'b0, val_q[bit_q]});
    if (px_q == $signed(w_eff) - XW'(1)) begin
      nx = '0;
      ny = py_q + YW'(1);
    end else begin
      nx = px_q + XW'(1);
      ny = py_q;
    end
    if (in_if.payload.luma == 15'd0) in_cls = hmt_pkg::CLS_ZERO;
    else if (in_if.payload.luma == hmt_pkg::HIT_VALUE) in_cls = hmt_pkg::CLS_HIT;
    else in_cls = hmt_pkg::CLS_OTHER;
  end

  // Steer RAM ports
  always_comb begin
    src_we    = 1'b0;
    src_waddr = wp_q;
    src_wdata = in_cls;
    res_we    = (state_q == S_PIX_WR);
    res_waddr = pix_q;
    res_wdata = hit_q;
    res_raddr = (state_q == S_IDLE) ? rp_q : pix_q;
    if (state_q == S_IDLE && in_acc && !in_if.payload.mode) begin
      src_we = 1'b1;
    end else if (state_q == S_CP_WR) begin
      src_we    = 1'b1;
      src_waddr = pix_q;
      src_wdata = {1'b0, res_rdata};
    end
  end

  hmt_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .raddr_i (tap_addr_q),
    .rdata_o (src_rdata)
  );

  hmt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  // Accept only when idle, with no configuration write or read pending, and the output can take a result
  assign in_if.ready = (state_q == S_IDLE) && !cfg_busy_q && !pend_q &&
                       (!out_valid_q || out_if.ready);
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= 10'd320;
      fh_q       <= 10'd240;
      kw_q       <= 3'd3;
      kh_q       <= 3'd3;
      care_q     <= 49'd250;
      val_q      <= 49'd50;
      npass_q    <= 8'd1;
      cfg_busy_q <= 1'b1;
    end else begin
      cfg_busy_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hmt_pkg::CFG_FRAME_WIDTH:   fw_q   <= cfg_data_i[9:0];
          hmt_pkg::CFG_FRAME_HEIGHT:  fh_q   <= cfg_data_i[9:0];
          hmt_pkg::CFG_KERNEL_WIDTH:  kw_q   <= cfg_data_i[2:0];
          hmt_pkg::CFG_KERNEL_HEIGHT: kh_q   <= cfg_data_i[2:0];
          hmt_pkg::CFG_CARE_MASK:     care_q <= cfg_data_i[48:0];
          hmt_pkg::CFG_VALUE_MASK:    val_q  <= cfg_data_i[48:0];
          hmt_pkg::CFG_PASS_COUNT: begin
            if (cfg_data_i[7:0] != 8'd0) npass_q <= cfg_data_i[7:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_q.pixel_value <= res_rdata ? hmt_pkg::HIT_VALUE : 15'd0;
      out_q.frame_end   <= pend_end_q;
    end
  end

  // Sequencer: load, tap sweep, result write, copy-back, drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      frame_rdy_q <= 1'b0;
      pend_q      <= 1'b0;
      pend_end_q  <= 1'b0;
      pix_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      r_q         <= '0;
      c_q         <= '0;
      bit_q       <= '0;
      tap_addr_q  <= '0;
      hit_q       <= 1'b1;
      pass_q      <= '0;
    end else begin
      pend_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc && !in_if.payload.mode) begin
            // Store sample; the last one starts the passes
            if ({1'b0, wp_q} == n_q - NW'(1)) begin
              wp_q        <= '0;
              rp_q        <= '0;
              frame_rdy_q <= 1'b1;
              pass_q      <= '0;
              pix_q       <= '0;
              px_q        <= '0;
              py_q        <= '0;
              tx_q        <= -XW'(kx);
              ty_q        <= -YW'(ky);
              tap_addr_q  <= -koff_q;
              r_q         <= '0;
              c_q         <= '0;
              bit_q       <= '0;
              hit_q       <= 1'b1;
              state_q     <= S_TAP_RD;
            end else begin
              wp_q <= wp_q + AW'(1);
            end
          end else if (in_acc && frame_rdy_q) begin
            // Read result and advance with wrap
            pend_q     <= 1'b1;
            pend_end_q <= ({1'b0, rp_q} == n_q - NW'(1));
            rp_q       <= ({1'b0, rp_q} == n_q - NW'(1)) ? '0 : rp_q + AW'(1);
          end
          if (cfg_we_i && (cfg_idx_i == hmt_pkg::CFG_FRAME_WIDTH ||
                           cfg_idx_i == hmt_pkg::CFG_FRAME_HEIGHT)) begin
            wp_q        <= '0;
            rp_q        <= '0;
            frame_rdy_q <= 1'b0;
          end
        end
        S_TAP_RD, S_TAP_CMP: begin
          if (state_q == S_TAP_RD && tap_ok) begin
            state_q <= S_TAP_CMP;
          end else begin
            if (state_q == S_TAP_CMP && !cls_match) hit_q <= 1'b0;
            // Advance to the next tap, or to the result write after the last tap
            if (last_tap) begin
              state_q <= S_PIX_WR;
            end else begin
              state_q <= S_TAP_RD;
              bit_q   <= bit_q + 6'd1;
              if (c_q == kw_eff - 3'd1) begin
                c_q        <= '0;
                r_q        <= r_q + 3'd1;
                tx_q       <= px_q - XW'(kx);
                ty_q       <= ty_q + YW'(1);
                tap_addr_q <= tap_addr_q + rstep_q;
              end else begin
                c_q        <= c_q + 3'd1;
                tx_q       <= tx_q + XW'(1);
                tap_addr_q <= tap_addr_q + AW'(1);
              end
            end
          end
        end
        S_PIX_WR: begin
          if (last_pix) begin
            pix_q   <= '0;
            state_q <= S_CP_RD;
          end else begin
            pix_q      <= pix_q + AW'(1);
            px_q       <= nx;
            py_q       <= ny;
            tx_q       <= nx - XW'(kx);
            ty_q       <= ny - YW'(ky);
            tap_addr_q <= pix_q + AW'(1) - koff_q;
            r_q        <= '0;
            c_q        <= '0;
            bit_q      <= '0;
            hit_q      <= 1'b1;
            state_q    <= S_TAP_RD;
          end
        end
        S_CP_RD: begin
          state_q <= S_CP_WR;
        end
        S_CP_WR: begin
          // Copy result back as the next pass source
          if (last_pix) begin
            if (pass_q == npass_q - 8'd1) begin
              state_q <= S_IDLE;
            end else begin
              pass_q     <= pass_q + 8'd1;
              pix_q      <= '0;
              px_q       <= '0;
              py_q       <= '0;
              tx_q       <= -XW'(kx);
              ty_q       <= -YW'(ky);
              tap_addr_q <= -koff_q;
              r_q        <= '0;
              c_q        <= '0;
              bit_q      <= '0;
              hit_q      <= 1'b1;
              state_q    <= S_TAP_RD;
            end
          end else begin
            pix_q   <= pix_q + AW'(1);
            state_q <= S_CP_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `HMT_ASSERT(a_pend_loads_out, pend_q |=> out_valid_q, "read result not presented")
  `HMT_ASSERT(a_busy_blocks_in, (state_q != S_IDLE) |-> !in_if.ready, "input taken mid pass")
  `HMT_ASSERT(a_pos_in_frame, (state_q == S_IDLE && !cfg_busy_q) |-> ({1'b0, wp_q} < n_q && {1'b0, rp_q} < n_q), "position beyond frame")

endmodule
